// File: hw/rtl/bdq_pkg.sv
// Package with the sizes, opcodes, state codes and ring index helper of the deque.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  // Store size and derived widths.
  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SUMW  = CW + 1;
  localparam int VW    = 32;

  // Command codes carried on the operation field.
  typedef enum logic [3:0] {
    OP_ADD_FRONT  = 4'd0,
    OP_ADD_BACK   = 4'd1,
    OP_DROP_FRONT = 4'd2,
    OP_DROP_BACK  = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_DELETE_EQ  = 4'd5,
    OP_EMIT_ALL   = 4'd6,
    OP_EMIT_FIRST = 4'd7,
    OP_EMIT_LAST  = 4'd8
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_DEL_RD,
    ST_DEL_CHK
  } state_t;

  // Ring slot of the element at a given offset from the head.
  // The offset is always below DEPTH, so one compare and subtract suffices.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(off);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bounded_deque_with_value_delete.sv
// Bounded double-ended queue of signed words with delete by value, kept in one memory.
//
// Usage: one command enters per input transaction (in_valid, in_stall, operation,
// argument). Results leave on the output channel (out_valid, out_stall) from an
// output register, so a finished result may wait while the sequencer goes on.
// Add, drop and clear give no result, except an add to a full store, which
// gives one result with add_dropped set. Delete by value walks every live
// element, reading and conditionally writing it back compacted. An emit walk
// reads each element through the single memory read port in the read state,
// then loads it into the output register in the output state. An emit that
// selects nothing gives one empty result. The block takes a new command only
// when the sequencer is idle; a stall on the output channel holds the current
// result and pauses an emit walk. Reset empties the store and returns the head
// to slot zero; the memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bounded_deque_with_value_delete (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [3:0]                      operation,
  input  wire logic signed [bdq_pkg::VW-1:0]   argument,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic signed [bdq_pkg::VW-1:0]   element_value,
  output      logic                            element_present,
  output      logic                            last_of_run,
  output      logic                            add_dropped
);

  // Element memory: one write port, one registered read port.
  logic [bdq_pkg::VW-1:0] mem [bdq_pkg::DEPTH];
  logic                   mem_we;
  logic [bdq_pkg::AW-1:0] mem_waddr;
  logic [bdq_pkg::VW-1:0] mem_wdata;
  logic                   mem_re;
  logic [bdq_pkg::AW-1:0] mem_raddr;
  logic [bdq_pkg::VW-1:0] mem_rdata;

  // Control state.
  bdq_pkg::state_t        state, state_next;
  logic [bdq_pkg::AW-1:0] head, head_next;
  logic [bdq_pkg::CW-1:0] count, count_next;
  logic                   out_valid_next;

  // Walk registers.
  logic [bdq_pkg::CW-1:0] idx, idx_next;
  logic [bdq_pkg::CW-1:0] start, start_next;
  logic [bdq_pkg::CW-1:0] len, len_next;
  logic [bdq_pkg::CW-1:0] kept, kept_next;
  logic [bdq_pkg::VW-1:0] key, key_next;
  logic                   one_dropped, one_dropped_next;

  // Output register load.
  logic                   out_load;
  logic [bdq_pkg::VW-1:0] out_value_next;
  logic                   out_present_next;
  logic                   out_last_next;
  logic                   out_dropped_next;

  logic                   accept;
  logic                   out_free;
  logic [bdq_pkg::CW-1:0] clamp_n;

  assign in_stall = (state != bdq_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Count argument for the partial emits: negative acts as zero, capped at the fill.
  always_comb begin
    if (argument[bdq_pkg::VW-1]) begin
      clamp_n = '0;
    end else if (unsigned'(argument) > bdq_pkg::VW'(count)) begin
      clamp_n = count;
    end else begin
      clamp_n = argument[bdq_pkg::CW-1:0];
    end
  end

  // Sequencer: next state, memory accesses and output loads.
  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    idx_next         = idx;
    start_next       = start;
    len_next         = len;
    kept_next        = kept;
    key_next         = key;
    one_dropped_next = one_dropped;
    mem_we           = 1'b0;
    mem_waddr        = head;
    mem_wdata        = argument;
    mem_re           = 1'b0;
    mem_raddr        = head;
    out_load         = 1'b0;
    out_value_next   = '0;
    out_present_next = 1'b0;
    out_last_next    = 1'b1;
    out_dropped_next = 1'b0;

    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (operation)
            bdq_pkg::OP_ADD_FRONT, bdq_pkg::OP_ADD_BACK: begin
              if (count == bdq_pkg::CW'(bdq_pkg::DEPTH)) begin
                one_dropped_next = 1'b1;
                state_next       = bdq_pkg::ST_ONE;
              end else if (operation == bdq_pkg::OP_ADD_FRONT) begin
                head_next  = (head == '0) ? bdq_pkg::AW'(bdq_pkg::DEPTH - 1)
                                          : head - 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = head_next;
                count_next = count + 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = bdq_pkg::slot(head, count);
                count_next = count + 1'b1;
              end
            end
            bdq_pkg::OP_DROP_FRONT: begin
              if (count != '0) begin
                head_next  = bdq_pkg::slot(head, bdq_pkg::CW'(1));
                count_next = count - 1'b1;
              end
            end
            bdq_pkg::OP_DROP_BACK: begin
              if (count != '0) begin
                count_next = count - 1'b1;
              end
            end
            bdq_pkg::OP_CLEAR: begin
              count_next = '0;
              head_next  = '0;
            end
            bdq_pkg::OP_DELETE_EQ: begin
              if (count != '0) begin
                idx_next   = '0;
                kept_next  = '0;
                key_next   = argument;
                state_next = bdq_pkg::ST_DEL_RD;
              end
            end
            bdq_pkg::OP_EMIT_ALL, bdq_pkg::OP_EMIT_FIRST, bdq_pkg::OP_EMIT_LAST: begin
              idx_next = '0;
              priority if (operation == bdq_pkg::OP_EMIT_ALL) begin
                len_next   = count;
                start_next = '0;
              end else if (operation == bdq_pkg::OP_EMIT_FIRST) begin
                len_next   = clamp_n;
                start_next = '0;
              end else begin
                len_next   = clamp_n;
                start_next = count - clamp_n;
              end
              if (len_next == '0) begin
                one_dropped_next = 1'b0;
                state_next       = bdq_pkg::ST_ONE;
              end else begin
                state_next = bdq_pkg::ST_EMIT_RD;
              end
            end
            default: begin
              // Unused operation codes are ignored.
            end
          endcase
        end
      end

      // Single flag or empty result.
      bdq_pkg::ST_ONE: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_dropped_next = one_dropped;
          state_next       = bdq_pkg::ST_IDLE;
        end
      end

      // Emit walk: read one element, then hand it to the output register.
      bdq_pkg::ST_EMIT_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = bdq_pkg::slot(head, start + idx);
        state_next = bdq_pkg::ST_EMIT_OUT;
      end

      bdq_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_value_next   = mem_rdata;
          out_present_next = 1'b1;
          out_last_next    = (idx + 1'b1 == len);
          idx_next         = idx + 1'b1;
          state_next       = out_last_next ? bdq_pkg::ST_IDLE : bdq_pkg::ST_EMIT_RD;
        end
      end

      // Delete walk: read each element and write survivors back compacted.
      bdq_pkg::ST_DEL_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = bdq_pkg::slot(head, idx);
        state_next = bdq_pkg::ST_DEL_CHK;
      end

      bdq_pkg::ST_DEL_CHK: begin
        if (mem_rdata != key) begin
          mem_we    = 1'b1;
          mem_waddr = bdq_pkg::slot(head, kept);
          mem_wdata = mem_rdata;
          kept_next = kept + 1'b1;
        end
        if (idx + 1'b1 == count) begin
          count_next = kept_next;
          state_next = bdq_pkg::ST_IDLE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = bdq_pkg::ST_DEL_RD;
        end
      end

      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = out_load || (out_valid && out_stall);

  // Memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    start       <= start_next;
    len         <= len_next;
    kept        <= kept_next;
    key         <= key_next;
    one_dropped <= one_dropped_next;
    if (out_load) begin
      element_value   <= out_value_next;
      element_present <= out_present_next;
      last_of_run     <= out_last_next;
      add_dropped     <= out_dropped_next;
    end
  end

`ifndef SYNTHESIS
  // The fill never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdq_pkg::CW'(bdq_pkg::DEPTH))
    else $error("element count above store size");

  // The head always names a real slot.
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < bdq_pkg::AW'(bdq_pkg::DEPTH - 1) || head == bdq_pkg::AW'(bdq_pkg::DEPTH - 1))
    else $error("head outside the store");

  // An emit walk never runs past its length.
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == bdq_pkg::ST_EMIT_OUT || state == bdq_pkg::ST_EMIT_RD) |-> (idx < len))
    else $error("emit index past run length");

  // A refused add is a lone result carrying no element.
  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && add_dropped) |-> (last_of_run && !element_present))
    else $error("dropped add flagged on an element result");
`endif

endmodule
`default_nettype wire
